@@ sv/btli_pkg.sv @@
// Shared types and constants for the breakpoint table linear interpolator.
// No dependencies; used by btli_muldiv and breakpoint_table_linear_interpolator.
package btli_pkg;

   // Field width of positions and values (signed Q16.16)
   localparam int unsigned DATA_W = 32;
   // Default number of breakpoints held in the table
   localparam int unsigned TABLE_DEPTH_DEFAULT = 64;
   // One restoring-divide step per quotient bit
   localparam int unsigned DIV_STEPS = DATA_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic {
      OP_APPEND = 1'b0,
      OP_QUERY  = 1'b1
   } btli_op_type;

   typedef enum logic {
      STATUS_OK   = 1'b0,
      STATUS_FULL = 1'b1
   } btli_status_type;

   typedef struct packed {
      btli_op_type              op;
      logic signed [DATA_W-1:0] position;
      logic signed [DATA_W-1:0] value;
   } btli_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic                     hit;
      btli_status_type          status;
   } btli_rsp_type;

   // Command into the multiply/divide unit
   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] mag;
      logic [DATA_W-1:0] off;
      logic [DATA_W-1:0] run;
   } btli_md_cmd_type;

   // Status back from the multiply/divide unit
   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quot;
   } btli_md_sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_DIV,
      ST_DONE
   } btli_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_DONE
   } btli_md_state_type;

endpackage

@@ sv/btli_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btli_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/btli_muldiv.sv @@
// Multiply/divide unit: floor((mag * off) / run) with one 32x32 multiply
// followed by a 32-step restoring divide. Depends on btli_pkg.
module btli_muldiv (
   input  logic                     clock,
   input  logic                     reset,
   input  btli_pkg::btli_md_cmd_type cmd,
   output btli_pkg::btli_md_sts_type sts
);
   import btli_pkg::*;

   btli_md_state_type     state_ff, state_in;
   logic [DATA_W-1:0]     a_ff, a_in;
   logic [DATA_W-1:0]     b_ff, b_in;
   logic [DATA_W-1:0]     d_ff, d_in;
   logic [DATA_W-1:0]     rem_ff, rem_in;
   logic [DATA_W-1:0]     low_ff, low_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [2*DATA_W-1:0]   prod;
   logic [DATA_W:0]       trial;
   logic [DATA_W:0]       diff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      cnt_ff <= cnt_in;
   end

   assign prod  = (2*DATA_W)'(a_ff) * (2*DATA_W)'(b_ff);
   // Shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, low_ff[DATA_W-1]};
   assign diff  = trial - {1'b0, d_ff};

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      cnt_in   = cnt_ff;
      sts.done = 1'b0;
      sts.quot = low_ff;
      unique case (state_ff)
         MD_IDLE: begin
            // Latch operands on start
            if (cmd.start) begin
               a_in     = cmd.mag;
               b_in     = cmd.off;
               d_in     = cmd.run;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            // High half is below the divisor, so the quotient fits in DATA_W bits
            rem_in   = prod[2*DATA_W-1:DATA_W];
            low_in   = prod[DATA_W-1:0];
            cnt_in   = '0;
            state_in = MD_DIV;
         end
         MD_DIV: begin
            // One quotient bit per cycle; quotient shifts into the low word
            if (!diff[DATA_W]) begin
               rem_in = diff[DATA_W-1:0];
               low_in = {low_ff[DATA_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DATA_W-1:0];
               low_in = {low_ff[DATA_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = MD_DONE;
            end
         end
         MD_DONE: begin
            sts.done = 1'b1;
            state_in = MD_IDLE;
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

endmodule

@@ sv/breakpoint_table_linear_interpolator.sv @@
// Breakpoint table with piecewise linear interpolation, signed Q16.16. An append
// word stores (position, value) at the end of the table, or is dropped with status
// set when the table holds TABLE_DEPTH points; its result goes through ST_DONE to
// the result register. A query word walks the table from index 0, each breakpoint
// in ST_READ and ST_CMP (RAM read, then compare against the query and the previous
// breakpoint); an exact match ends the walk, and a hit strictly inside an
// increasing interval goes through the multiply/divide unit (one 32x32 multiply,
// 32 restoring divide steps, then the quotient is handed back). An empty table
// answers without a walk. One word is in work at a time; req_ready is high only
// while idle, so the next word is taken only once the result is registered, and
// the result register lets it in while a result waits. Depends on btli_pkg,
// btli_ram and btli_muldiv.
module breakpoint_table_linear_interpolator #(
   parameter int unsigned TABLE_DEPTH = btli_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  btli_pkg::btli_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output btli_pkg::btli_rsp_type rsp_data
);
   import btli_pkg::*;

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

   btli_state_type           state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [DATA_W-1:0] qpos_ff, qpos_in;
   logic signed [DATA_W-1:0] prev_pos_ff, prev_pos_in;
   logic signed [DATA_W-1:0] prev_val_ff, prev_val_in;
   logic                     neg_ff, neg_in;
   logic signed [DATA_W-1:0] res_ff, res_in;
   logic                     hit_ff, hit_in;
   btli_status_type          status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   btli_rsp_type             rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic                     wr_en;
   logic signed [DATA_W-1:0] pos_rd;
   logic signed [DATA_W-1:0] val_rd;
   logic signed [DATA_W:0]   rise;
   logic [DATA_W:0]          mag;
   logic [DATA_W:0]          off;
   logic [DATA_W:0]          run;
   logic                     last_idx;
   btli_md_cmd_type          md_cmd;
   btli_md_sts_type          md_sts;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Store an append while the table has room
   assign wr_en = accept && (req_data.op == OP_APPEND) &&
                  (count_ff < CNT_W'(TABLE_DEPTH));

   btli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_pos_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_data.position),
      .rd_addr (idx_ff),
      .rd_data (pos_rd)
   );

   btli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_data.value),
      .rd_addr (idx_ff),
      .rd_data (val_rd)
   );

   btli_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (md_cmd),
      .sts   (md_sts)
   );

   // Interval operands: rise may be negative, off and run are positive on a hit
   assign rise = {val_rd[DATA_W-1], val_rd} - {prev_val_ff[DATA_W-1], prev_val_ff};
   assign mag  = rise[DATA_W] ? (-rise) : rise;
   assign off  = {qpos_ff[DATA_W-1], qpos_ff} - {prev_pos_ff[DATA_W-1], prev_pos_ff};
   assign run  = {pos_rd[DATA_W-1], pos_rd} - {prev_pos_ff[DATA_W-1], prev_pos_ff};

   assign last_idx = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk and result registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      qpos_ff     <= qpos_in;
      prev_pos_ff <= prev_pos_in;
      prev_val_ff <= prev_val_in;
      neg_ff      <= neg_in;
      res_ff      <= res_in;
      hit_ff      <= hit_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      qpos_in      = qpos_ff;
      prev_pos_in  = prev_pos_ff;
      prev_val_in  = prev_val_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      hit_in       = hit_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      md_cmd.start = 1'b0;
      md_cmd.mag   = mag[DATA_W-1:0];
      md_cmd.off   = off[DATA_W-1:0];
      md_cmd.run   = run[DATA_W-1:0];

      // Drop the result word once taken
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in    = '0;
               hit_in    = 1'b0;
               status_in = STATUS_OK;
               idx_in    = '0;
               qpos_in   = req_data.position;
               if (req_data.op == OP_APPEND) begin
                  if (wr_en) begin
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     status_in = STATUS_FULL;
                  end
                  state_in = ST_DONE;
               end else if (count_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // Address presented from idx_ff; data arrives next cycle
            state_in = ST_CMP;
         end
         ST_CMP: begin
            priority if (qpos_ff == pos_rd) begin
               res_in   = val_rd;
               hit_in   = 1'b1;
               state_in = ST_DONE;
            end else if ((idx_ff != '0) && (qpos_ff > prev_pos_ff) && (qpos_ff < pos_rd)) begin
               md_cmd.start = 1'b1;
               neg_in       = rise[DATA_W];
               state_in     = ST_DIV;
            end else begin
               // Advance to the next breakpoint or give up at the end
               prev_pos_in = pos_rd;
               prev_val_in = val_rd;
               if (last_idx) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_DIV: begin
            if (md_sts.done) begin
               res_in   = neg_ff ? (prev_val_ff - md_sts.quot) : (prev_val_ff + md_sts.quot);
               hit_in   = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.result_value = res_ff;
               rsp_data_in.hit          = hit_ff;
               rsp_data_in.status       = status_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
